// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high
`define KPVF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define KPVF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/kpvf_pkg.sv
// ----------------------------------------------------------------------------
// kpvf_pkg
// Types, codes and saturation helpers of the position/velocity Kalman filter.
// ----------------------------------------------------------------------------
package kpvf_pkg;

  // Field widths
  localparam int MODE_W  = 2;
  localparam int DT_W    = 17;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 31;
  localparam int IDX_W   = 2;
  localparam int COV_W   = 48;
  localparam int SUM_W   = 51;
  localparam int DEN_W   = 49;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_PREDICT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CORRECT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD_POS = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOAD_VEL = 2'd3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [IDX_W-1:0] REG_OBSERVATION_NOISE = 2'd1;
  localparam logic [IDX_W-1:0] REG_INITIAL_VARIANCE  = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 31'd65536;
  localparam logic [CFG_W-1:0] MAX31     = 31'h7FFF_FFFF;

  // Saturation limits on the wide sum
  localparam logic signed [SUM_W-1:0] LIM32_HI = 51'sh7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] LIM32_LO = -51'sh8000_0000;
  localparam logic signed [SUM_W-1:0] LIM48_HI = 51'sh7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] LIM48_LO = -51'sh8000_0000_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

  // Multiply steps: predict sequence, then correct sequence
  typedef enum logic [4:0] {
    OP_D2,
    OP_D3,
    OP_D4,
    OP_XV,
    OP_XU,
    OP_VU,
    OP_PA,
    OP_PB,
    OP_PACC,
    OP_P00,
    OP_P01,
    OP_P11,
    OP_CX,
    OP_CV,
    OP_C11,
    OP_C01,
    OP_C00
  } op_t;

  typedef struct packed {
    logic                    start;
    logic signed [COV_W-1:0] a;
    logic signed [COV_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [COV_W-1:0] result;
  } mul_rsp_t;

  typedef struct packed {
    logic                    start;
    logic signed [COV_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > LIM32_HI) c = LIM32_HI;
    else if (v < LIM32_LO) c = LIM32_LO;
    return c[VAL_W-1:0];
  endfunction

  function automatic logic signed [COV_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > LIM48_HI) c = LIM48_HI;
    else if (v < LIM48_LO) c = LIM48_LO;
    return c[COV_W-1:0];
  endfunction

  // Halve, truncating toward zero
  function automatic logic signed [COV_W-1:0] half(input logic signed [COV_W-1:0] m);
    logic signed [COV_W-1:0] t;
    t = m + COV_W'({1'b0, m[COV_W-1]});
    return t >>> 1;
  endfunction

endpackage

// File: rtl/kpvf_if.sv
// ----------------------------------------------------------------------------
// kpvf_if
// Valid/ready channels of the filter: sample in, result out, register write.
// ----------------------------------------------------------------------------
interface kpvf_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic [kpvf_pkg::MODE_W-1:0]            mode;
  logic [kpvf_pkg::DT_W-1:0]              time_step;
  logic signed [kpvf_pkg::VAL_W-1:0]      acceleration;
  logic signed [kpvf_pkg::VAL_W-1:0]      measured_position;
  logic signed [kpvf_pkg::VAL_W-1:0]      load_value;

  modport source (output valid, mode, time_step, acceleration, measured_position,
                  load_value, input ready);
  modport sink   (input valid, mode, time_step, acceleration, measured_position,
                  load_value, output ready);
endinterface

interface kpvf_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [kpvf_pkg::VAL_W-1:0] position;
  logic signed [kpvf_pkg::VAL_W-1:0] velocity;
  logic [kpvf_pkg::CFG_W-1:0]        position_variance;

  modport source (output valid, position, velocity, position_variance, input ready);
  modport sink   (input valid, position, velocity, position_variance, output ready);
endinterface

interface kpvf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [kpvf_pkg::IDX_W-1:0]   index;
  logic [kpvf_pkg::CFG_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/kalman_pos_vel_filter.sv
// ----------------------------------------------------------------------------
// kalman_pos_vel_filter
// Two-state position/velocity Kalman filter, fixed point, one shared
// multiplier and one shared divider under a step sequencer.
// ----------------------------------------------------------------------------
// Channels: sample (sink) carries one item per transfer, result (source)
// returns one item per sample, cfg (sink) writes registers 0..2 and is
// always ready; writing initial_variance also reloads the covariance.
// Work per item, from transfer to result valid:
//   load position / velocity : the value is written at the transfer
//   predict                  : 12 multiplies
//   correct                  : 2 divides, then 5 multiplies
//   correct with p00 + r <= 0: no divide and no multiply
// The multiplier runs three 48x16 partial products per operation and the
// divider yields one quotient bit per cycle; these two units set the rate.
// sample.ready is high only while idle; one item is worked at a time.
// A finished result waits in the output register while the next item is
// taken; with the receiver stalled the block holds in its final step.
// Reset: estimates zero, registers and covariance diagonal at 65536.
// ----------------------------------------------------------------------------
module kalman_pos_vel_filter #(
  parameter int FRAC_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  kpvf_cfg_if.sink      cfg,
  kpvf_sample_if.sink   sample,
  kpvf_result_if.source result
);

  localparam int VW = kpvf_pkg::VAL_W;
  localparam int PW = kpvf_pkg::COV_W;
  localparam int SW = kpvf_pkg::SUM_W;
  localparam int DW = kpvf_pkg::DEN_W;
  localparam int CW = kpvf_pkg::CFG_W;

  kpvf_pkg::state_t state;
  kpvf_pkg::state_t state_next;
  kpvf_pkg::op_t    op;

  logic                    launch;
  logic                    launch_next;
  logic                    div_sel;
  logic                    last_op;
  logic                    out_load;
  logic                    s_pos;
  logic                    in_xfer;

  logic [CW-1:0]           sg;
  logic [CW-1:0]           rn;
  logic [kpvf_pkg::DT_W-1:0] dt_r;
  logic signed [VW-1:0]    u_r;
  logic signed [VW-1:0]    z_r;
  logic signed [VW-1:0]    x;
  logic signed [VW-1:0]    v;
  logic signed [PW-1:0]    p00;
  logic signed [PW-1:0]    p01;
  logic signed [PW-1:0]    p11;
  logic signed [PW-1:0]    d2;
  logic signed [PW-1:0]    d3;
  logic signed [PW-1:0]    d4;
  logic signed [PW-1:0]    a_r;
  logic signed [PW-1:0]    b_r;
  logic signed [SW-1:0]    acc;
  logic signed [DW-1:0]    s_r;
  logic signed [DW-1:0]    s_next;
  logic signed [VW-1:0]    y_r;
  logic signed [VW-1:0]    k0;
  logic signed [VW-1:0]    k1;

  logic signed [PW-1:0]    dt48;
  logic signed [PW-1:0]    sg48;
  logic signed [PW-1:0]    m;

  logic                    out_valid;
  logic signed [VW-1:0]    out_pos;
  logic signed [VW-1:0]    out_vel;
  logic [CW-1:0]           out_var;

  kpvf_pkg::mul_req_t mreq;
  kpvf_pkg::mul_rsp_t mrsp;
  kpvf_pkg::div_req_t dreq;
  kpvf_pkg::div_rsp_t drsp;

  kpvf_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  kpvf_divq #(.FRAC_BITS(FRAC_BITS)) u_divq (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign in_xfer = sample.valid && sample.ready;
  assign m       = mrsp.result;
  assign dt48    = $signed({{(PW - kpvf_pkg::DT_W){1'b0}}, dt_r});
  assign sg48    = $signed({{(PW - CW){1'b0}}, sg});
  assign s_next  = DW'(p00) + $signed({{(DW - CW){1'b0}}, rn});
  assign s_pos   = !s_next[DW-1] && (s_next != '0);
  assign last_op = (op == kpvf_pkg::OP_P11) || (op == kpvf_pkg::OP_C00);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      kpvf_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (sample.mode == kpvf_pkg::MODE_PREDICT) state_next = kpvf_pkg::S_MUL;
          else if (sample.mode == kpvf_pkg::MODE_CORRECT) state_next = kpvf_pkg::S_SUM;
          else state_next = kpvf_pkg::S_DONE;
        end
      end
      kpvf_pkg::S_SUM:  state_next = s_pos ? kpvf_pkg::S_DIV : kpvf_pkg::S_DONE;
      kpvf_pkg::S_DIV: begin
        if (drsp.done && div_sel) state_next = kpvf_pkg::S_MUL;
      end
      kpvf_pkg::S_MUL: begin
        if (mrsp.done && last_op) state_next = kpvf_pkg::S_DONE;
      end
      kpvf_pkg::S_DONE: begin
        if (!out_valid || result.ready) state_next = kpvf_pkg::S_IDLE;
      end
      default: state_next = kpvf_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    sample.ready = (state == kpvf_pkg::S_IDLE);
    out_load     = (state == kpvf_pkg::S_DONE) && (!out_valid || result.ready);
    launch_next  = (state_next != state)
                || ((state == kpvf_pkg::S_MUL) && mrsp.done)
                || ((state == kpvf_pkg::S_DIV) && drsp.done);
    dreq.start   = (state == kpvf_pkg::S_DIV) && launch;
    dreq.num     = div_sel ? p01 : p00;
    dreq.den     = s_r;
  end

  // Multiplier launch and operand select per step
  always_comb begin
    mreq.start = (state == kpvf_pkg::S_MUL) && launch;
    unique case (op)
      kpvf_pkg::OP_D2:   begin mreq.a = dt48;    mreq.b = dt48; end
      kpvf_pkg::OP_D3:   begin mreq.a = d2;      mreq.b = dt48; end
      kpvf_pkg::OP_D4:   begin mreq.a = d3;      mreq.b = dt48; end
      kpvf_pkg::OP_XV:   begin mreq.a = PW'(v);  mreq.b = dt48; end
      kpvf_pkg::OP_XU:   begin mreq.a = PW'(u_r); mreq.b = d2;  end
      kpvf_pkg::OP_VU:   begin mreq.a = PW'(u_r); mreq.b = dt48; end
      kpvf_pkg::OP_PA:   begin mreq.a = p01;     mreq.b = dt48; end
      kpvf_pkg::OP_PB:   begin mreq.a = p11;     mreq.b = dt48; end
      kpvf_pkg::OP_PACC: begin mreq.a = b_r;     mreq.b = dt48; end
      kpvf_pkg::OP_P00:  begin mreq.a = sg48;    mreq.b = d4;   end
      kpvf_pkg::OP_P01:  begin mreq.a = sg48;    mreq.b = d3;   end
      kpvf_pkg::OP_P11:  begin mreq.a = sg48;    mreq.b = d2;   end
      kpvf_pkg::OP_CX:   begin mreq.a = PW'(k0); mreq.b = PW'(y_r); end
      kpvf_pkg::OP_CV:   begin mreq.a = PW'(k1); mreq.b = PW'(y_r); end
      kpvf_pkg::OP_C11:  begin mreq.a = PW'(k1); mreq.b = p01;  end
      kpvf_pkg::OP_C01:  begin mreq.a = PW'(k0); mreq.b = p01;  end
      kpvf_pkg::OP_C00:  begin mreq.a = PW'(k0); mreq.b = p00;  end
      default:           begin mreq.a = '0;      mreq.b = '0;   end
    endcase
  end

  // Sequencer state and filter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kpvf_pkg::S_IDLE;
      launch    <= 1'b0;
      out_valid <= 1'b0;
      sg        <= kpvf_pkg::CFG_RESET;
      rn        <= kpvf_pkg::CFG_RESET;
      x         <= '0;
      v         <= '0;
      p00       <= PW'(kpvf_pkg::CFG_RESET);
      p01       <= '0;
      p11       <= PW'(kpvf_pkg::CFG_RESET);
      div_sel   <= 1'b0;
      op        <= kpvf_pkg::OP_D2;
    end else begin
      state  <= state_next;
      launch <= launch_next;

      // register writes
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          kpvf_pkg::REG_PROCESS_NOISE:     sg <= cfg.data;
          kpvf_pkg::REG_OBSERVATION_NOISE: rn <= cfg.data;
          kpvf_pkg::REG_INITIAL_VARIANCE: begin
            p00 <= PW'(cfg.data);
            p01 <= '0;
            p11 <= PW'(cfg.data);
          end
          default: ;
        endcase
      end

      // sample transfer
      if (in_xfer) begin
        dt_r <= sample.time_step;
        u_r  <= sample.acceleration;
        z_r  <= sample.measured_position;
        op   <= kpvf_pkg::OP_D2;
        if (sample.mode == kpvf_pkg::MODE_LOAD_POS) x <= sample.load_value;
        if (sample.mode == kpvf_pkg::MODE_LOAD_VEL) v <= sample.load_value;
      end

      // innovation and denominator
      if (state == kpvf_pkg::S_SUM) begin
        s_r     <= s_next;
        y_r     <= kpvf_pkg::sat32(SW'(z_r) - SW'(x));
        div_sel <= 1'b0;
      end

      // gains
      if (state == kpvf_pkg::S_DIV && drsp.done) begin
        if (div_sel) begin
          k1 <= drsp.quot;
          op <= kpvf_pkg::OP_CX;
        end else begin
          k0 <= drsp.quot;
        end
        div_sel <= ~div_sel;
      end

      // multiply write-back
      if (state == kpvf_pkg::S_MUL && mrsp.done) begin
        op <= kpvf_pkg::op_t'(op + 1'b1);
        unique case (op)
          kpvf_pkg::OP_D2:   d2  <= m;
          kpvf_pkg::OP_D3:   d3  <= m;
          kpvf_pkg::OP_D4:   d4  <= m;
          kpvf_pkg::OP_XV:   acc <= SW'(x) + SW'(m);
          kpvf_pkg::OP_XU:   x   <= kpvf_pkg::sat32(acc + SW'(kpvf_pkg::half(m)));
          kpvf_pkg::OP_VU:   v   <= kpvf_pkg::sat32(SW'(v) + SW'(m));
          kpvf_pkg::OP_PA:   a_r <= kpvf_pkg::sat48(SW'(p00) + SW'(m));
          kpvf_pkg::OP_PB:   b_r <= kpvf_pkg::sat48(SW'(p01) + SW'(m));
          kpvf_pkg::OP_PACC: acc <= SW'(a_r) + SW'(m);
          kpvf_pkg::OP_P00:  p00 <= kpvf_pkg::sat48(acc + SW'(m));
          kpvf_pkg::OP_P01:  p01 <= kpvf_pkg::sat48(SW'(b_r) + SW'(m));
          kpvf_pkg::OP_P11:  p11 <= kpvf_pkg::sat48(SW'(p11) + SW'(m));
          kpvf_pkg::OP_CX:   x   <= kpvf_pkg::sat32(SW'(x) + SW'(m));
          kpvf_pkg::OP_CV:   v   <= kpvf_pkg::sat32(SW'(v) + SW'(m));
          kpvf_pkg::OP_C11:  p11 <= kpvf_pkg::sat48(SW'(p11) - SW'(m));
          kpvf_pkg::OP_C01:  p01 <= kpvf_pkg::sat48(SW'(p01) - SW'(m));
          kpvf_pkg::OP_C00:  p00 <= kpvf_pkg::sat48(SW'(p00) - SW'(m));
          default: ;
        endcase
      end

      // result register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, variance clamped to [0, 2^31-1]
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos <= x;
      out_vel <= v;
      if (p00[PW-1]) out_var <= '0;
      else if (|p00[PW-2:CW]) out_var <= kpvf_pkg::MAX31;
      else out_var <= p00[CW-1:0];
    end
  end

  assign cfg.ready                = 1'b1;
  assign result.valid             = out_valid;
  assign result.position          = out_pos;
  assign result.velocity          = out_vel;
  assign result.position_variance = out_var;

endmodule

// File: rtl/kpvf_mulq.sv
// ----------------------------------------------------------------------------
// kpvf_mulq
// Shared fixed-point multiplier: 48x48 magnitude product built from 48x16
// partial products, one per cycle, then scaled, saturated and signed.
// ----------------------------------------------------------------------------
module kpvf_mulq #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  kpvf_pkg::mul_req_t req,
  output kpvf_pkg::mul_rsp_t rsp
);

  localparam int OPW = kpvf_pkg::COV_W;
  localparam int CHW = 16;
  localparam int NCH = OPW / CHW;
  localparam int PW  = 2 * OPW;
  localparam int CW  = $clog2(NCH);

  localparam logic signed [OPW-1:0] MAX48 = {1'b0, {(OPW-1){1'b1}}};
  localparam logic signed [OPW-1:0] MIN48 = {1'b1, {(OPW-1){1'b0}}};

  logic [OPW-1:0]          ua;
  logic [OPW-1:0]          ub;
  logic                    neg;
  logic [PW-1:0]           acc;
  logic                    busy;
  logic                    fin;
  logic [CW-1:0]           cnt;
  logic                    done;
  logic signed [OPW-1:0]   result;

  logic [PW-1:0]           scaled;
  logic                    ovf;
  logic signed [OPW-1:0]   res_next;

  // Scale, saturate and restore the sign
  always_comb begin
    scaled = acc >> FRAC_BITS;
    ovf    = |scaled[PW-1:OPW-1];
    if (ovf) begin
      res_next = neg ? MIN48 : MAX48;
    end else if (neg) begin
      res_next = -$signed(scaled[OPW-1:0]);
    end else begin
      res_next = $signed(scaled[OPW-1:0]);
    end
  end

  // Partial product sequencing, most significant chunk first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        ua   <= req.a[OPW-1] ? OPW'(-req.a) : OPW'(req.a);
        ub   <= req.b[OPW-1] ? OPW'(-req.b) : OPW'(req.b);
        neg  <= req.a[OPW-1] ^ req.b[OPW-1];
      end else if (busy) begin
        acc <= (acc << CHW) + PW'(ua * ub[OPW-1 -: CHW]);
        ub  <= ub << CHW;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NCH - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin    <= 1'b0;
        done   <= 1'b1;
        result <= res_next;
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

// File: rtl/kpvf_divq.sv
// ----------------------------------------------------------------------------
// kpvf_divq
// Restoring divider for the gain: (|num| << FRAC_BITS) / den, one quotient
// bit per cycle, magnitude saturated to 2^31-1, sign of the numerator.
// ----------------------------------------------------------------------------
module kpvf_divq #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  kpvf_pkg::div_req_t req,
  output kpvf_pkg::div_rsp_t rsp
);

  localparam int MW = kpvf_pkg::COV_W;
  localparam int NW = MW + FRAC_BITS;
  localparam int QW = 31;
  localparam int RW = kpvf_pkg::DEN_W;
  localparam int CW = $clog2(QW);

  logic [MW-1:0]   nmag;
  logic [NW-1:0]   nfull;
  logic [NW-1:0]   ntop;
  logic            sat;

  logic [RW-1:0]   rem;
  logic [RW-1:0]   den;
  logic [QW-1:0]   nsh;
  logic [QW-1:0]   q;
  logic            neg;
  logic            busy;
  logic            fin;
  logic [CW-1:0]   cnt;
  logic            done;
  logic signed [kpvf_pkg::VAL_W-1:0] quot;

  logic [RW:0]     trial;
  logic            qbit;

  // Numerator setup and quotient overflow test
  always_comb begin
    nmag  = req.num[MW-1] ? MW'(-req.num) : MW'(req.num);
    nfull = {nmag, {FRAC_BITS{1'b0}}};
    ntop  = nfull >> QW;
    sat   = ntop >= NW'(unsigned'(req.den));
    trial = {rem, nsh[QW-1]};
    qbit  = trial >= (RW + 1)'(den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        neg <= req.num[MW-1];
        den <= RW'(unsigned'(req.den));
        cnt <= '0;
        if (sat) begin
          q   <= {QW{1'b1}};
          fin <= 1'b1;
        end else begin
          rem  <= ntop[RW-1:0];
          nsh  <= nfull[QW-1:0];
          q    <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= qbit ? RW'(trial - (RW + 1)'(den)) : trial[RW-1:0];
        q   <= {q[QW-2:0], qbit};
        nsh <= nsh << 1;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        quot <= neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// File: rtl/kpvf_checker.sv
// ----------------------------------------------------------------------------
// kpvf_checker
// Port-level checks of the filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kpvf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [kpvf_pkg::VAL_W-1:0]    out_position
);

  // one item at a time: busy right after a sample transfer
  `KPVF_ASSERT(a_busy_after_in, clk, rst, (in_valid && in_ready) |=> !in_ready, "ready after transfer")

  // no result straight out of reset
  `KPVF_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result valid after reset")

  // a stalled result stays
  `KPVF_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> out_valid, "result dropped")

  // and keeps its payload
  `KPVF_ASSERT(a_out_stable, clk, rst, (out_valid && !out_ready) |=> $stable(out_position), "result changed while stalled")

endmodule

bind kalman_pos_vel_filter kpvf_checker u_kpvf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample.valid),
  .in_ready     (sample.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_position (result.position)
);

// File: test/kpvf_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpvf_tb_pkg
// Fixed-point arithmetic used to predict the position/velocity filter.
// ----------------------------------------------------------------------------
package kpvf_tb_pkg;

  localparam int QF = 16;
  localparam longint Q48_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint Q48_MIN = -64'sh8000_0000_0000;
  localparam longint Q32_MAX = 64'sh7FFF_FFFF;
  localparam longint Q32_MIN = -64'sh8000_0000;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // (a*b) >> QF toward zero, saturated to 48 bits
  function automatic longint qmul(input longint a, input longint b);
    logic [127:0] ma, mb, pr;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? 128'(-a) : 128'(a);
    mb = b < 0 ? 128'(-b) : 128'(b);
    pr = (ma * mb) >> QF;
    if (pr > 128'(Q48_MAX)) return neg ? Q48_MIN : Q48_MAX;
    return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
  endfunction

  // (p << QF) / s for s > 0, toward zero, magnitude capped at 2^31-1
  function automatic longint qdiv(input longint p, input longint s);
    logic [127:0] mp, q;
    mp = p < 0 ? 128'(-p) : 128'(p);
    q = (mp << QF) / 128'(s);
    if (q > 128'(Q32_MAX)) q = 128'(Q32_MAX);
    return p < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

endpackage

// File: test/tb_kalman_pos_vel_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kalman_pos_vel_filter
// Drives predict, correct and load items with random gaps and stalls, checks
// every result against a fixed-point predictor of the filter state, and
// changes the noise and variance registers between phases.
// ----------------------------------------------------------------------------
module tb_kalman_pos_vel_filter;
  import kpvf_pkg::*;
  import kpvf_tb_pkg::*;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [DT_W-1:0]          dt;
    logic signed [VAL_W-1:0]  accel;
    logic signed [VAL_W-1:0]  meas;
    logic signed [VAL_W-1:0]  ld;
  } sample_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  pos;
    logic signed [VAL_W-1:0]  vel;
    logic [CFG_W-1:0]         pvar;
  } estimate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kpvf_cfg_if    cfg_ch();
  kpvf_sample_if smp_ch();
  kpvf_result_if res_ch();

  kalman_pos_vel_filter dut (
    .clk(clk), .rst(rst), .cfg(cfg_ch.sink), .sample(smp_ch.sink), .result(res_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  longint sigma, r_noise, x_pos, x_vel, p00, p01, p11;
  sample_t   pending_samples[$];
  estimate_t expected_estimates[$];
  int  errors = 0;
  int  sent = 0;
  int  stall_hold = 0;
  int  idle_cycles = 0;

  function automatic void filter_reset();
    sigma = 65536; r_noise = 65536;
    x_pos = 0; x_vel = 0; p00 = 65536; p01 = 0; p11 = 65536;
  endfunction

  function automatic void filter_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    case (idx)
      REG_PROCESS_NOISE:     sigma = v;
      REG_OBSERVATION_NOISE: r_noise = v;
      REG_INITIAL_VARIANCE: begin
        p00 = v; p01 = 0; p11 = v;
      end
      default: ;
    endcase
  endfunction

  function automatic estimate_t filter_step(input sample_t s);
    longint dt, u, d2, d3, d4, a, b, den, k0, k1, y, q00, q01;
    estimate_t e;
    case (s.mode)
      MODE_PREDICT: begin
        dt = s.dt; u = s.accel;
        d2 = qmul(dt, dt); d3 = qmul(d2, dt); d4 = qmul(d3, dt);
        x_pos = clip(x_pos + qmul(x_vel, dt) + qmul(u, d2) / 2, Q32_MIN, Q32_MAX);
        x_vel = clip(x_vel + qmul(u, dt), Q32_MIN, Q32_MAX);
        a = clip(p00 + qmul(p01, dt), Q48_MIN, Q48_MAX);
        b = clip(p01 + qmul(p11, dt), Q48_MIN, Q48_MAX);
        p00 = clip(a + qmul(b, dt) + qmul(sigma, d4), Q48_MIN, Q48_MAX);
        p01 = clip(b + qmul(sigma, d3), Q48_MIN, Q48_MAX);
        p11 = clip(p11 + qmul(sigma, d2), Q48_MIN, Q48_MAX);
      end
      MODE_CORRECT: begin
        den = p00 + r_noise;
        // nonpositive innovation variance leaves the state alone
        if (den > 0) begin
          q00 = p00; q01 = p01;
          k0 = qdiv(q00, den); k1 = qdiv(q01, den);
          y = clip(longint'(s.meas) - x_pos, Q32_MIN, Q32_MAX);
          x_pos = clip(x_pos + qmul(k0, y), Q32_MIN, Q32_MAX);
          x_vel = clip(x_vel + qmul(k1, y), Q32_MIN, Q32_MAX);
          p00 = clip(q00 - qmul(k0, q00), Q48_MIN, Q48_MAX);
          p01 = clip(q01 - qmul(k0, q01), Q48_MIN, Q48_MAX);
          p11 = clip(p11 - qmul(k1, q01), Q48_MIN, Q48_MAX);
        end
      end
      MODE_LOAD_POS: x_pos = longint'(s.ld);
      default:       x_vel = longint'(s.ld);
    endcase
    e.pos = x_pos[31:0];
    e.vel = x_vel[31:0];
    e.pvar = CFG_W'(clip(p00, 0, Q32_MAX));
    return e;
  endfunction

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 2 * 655360)) - 655360);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.mode = $urandom_range(0, 9) < 4 ? MODE_PREDICT :
             ($urandom_range(0, 5) < 4 ? MODE_CORRECT :
             ($urandom_range(0, 1) ? MODE_LOAD_POS : MODE_LOAD_VEL));
    s.dt = $urandom_range(0, 7) == 0 ? DT_W'($urandom) : DT_W'($urandom_range(0, 40000));
    s.accel = rnd32();
    s.meas = rnd32();
    s.ld = rnd32();
    return s;
  endfunction

  function automatic sample_t mk(input logic [MODE_W-1:0] m, input logic [DT_W-1:0] dt,
                                 input logic [31:0] v);
    sample_t s;
    s.mode = m; s.dt = dt; s.accel = v; s.meas = v; s.ld = v;
    return s;
  endfunction

  // Sample driver: random gap before each transfer
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      smp_ch.valid <= 1'b0;
      gap_left <= $urandom_range(0, 6);
    end else if (smp_ch.valid && !smp_ch.ready) begin
      // hold the offered item
    end else begin
      if (smp_ch.valid) begin
        expected_estimates.push_back(filter_step(pending_samples.pop_front()));
        sent <= sent + 1;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        smp_ch.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        // head of the queue is the next item to offer
        smp_ch.valid <= 1'b1;
        {smp_ch.mode, smp_ch.time_step, smp_ch.acceleration, smp_ch.measured_position,
         smp_ch.load_value} <= pending_samples[0];
        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
      end else begin
        smp_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor with random stalls and an optional long hold-off
  int stall_left = 0;
  always @(posedge clk) begin
    estimate_t got, want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.pos = res_ch.position;
        got.vel = res_ch.velocity;
        got.pvar = res_ch.position_variance;
        if (expected_estimates.size() == 0) begin
          $error("result with no item pending");
          errors <= errors + 1;
        end else begin
          want = expected_estimates.pop_front();
          if (got.pos !== want.pos) begin
            $error("position expected %0d actual %0d", want.pos, got.pos);
            errors <= errors + 1;
          end
          if (got.vel !== want.vel) begin
            $error("velocity expected %0d actual %0d", want.vel, got.vel);
            errors <= errors + 1;
          end
          if (got.pvar !== want.pvar) begin
            $error("position_variance expected %0d actual %0d", want.pvar, got.pvar);
            errors <= errors + 1;
          end
        end
      end
      if (stall_hold > 0) begin
        res_ch.ready <= 1'b0;
        stall_hold <= stall_hold - 1;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        res_ch.ready <= 1'b1;
        if (res_ch.valid && res_ch.ready)
          stall_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
        stall_hold > 0 || pending_samples.size() == 0 && expected_estimates.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == 5000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    filter_write(idx, v);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait for all results, then let the block settle before a register write
  task automatic drain();
    while (pending_samples.size() > 0 || smp_ch.valid || expected_estimates.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) pending_samples.push_back(rand_sample());
  endtask

  initial begin
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    smp_ch.valid = 1'b0; smp_ch.mode = '0; smp_ch.time_step = '0;
    smp_ch.acceleration = '0; smp_ch.measured_position = '0; smp_ch.load_value = '0;
    res_ch.ready = 1'b0;
    filter_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every mode, zero and large steps
    pending_samples.push_back(mk(MODE_PREDICT, 17'd0, 32'd0));
    pending_samples.push_back(mk(MODE_PREDICT, 17'd65536, 32'h0001_0000));
    pending_samples.push_back(mk(MODE_CORRECT, 17'd0, 32'h0004_0000));
    pending_samples.push_back(mk(MODE_LOAD_POS, 17'd0, 32'h7FFF_FFFF));
    pending_samples.push_back(mk(MODE_LOAD_VEL, 17'd0, 32'h8000_0000));
    pending_samples.push_back(mk(MODE_PREDICT, 17'h1FFFF, 32'h7FFF_FFFF));
    pending_samples.push_back(mk(MODE_PREDICT, 17'h1FFFF, 32'h8000_0000));
    pending_samples.push_back(mk(MODE_CORRECT, 17'h1FFFF, 32'h8000_0000));
    pending_samples.push_back(mk(MODE_CORRECT, 17'd1, 32'h7FFF_FFFF));
    pending_samples.push_back(mk(MODE_LOAD_POS, 17'h1FFFF, 32'hFFFF_FFFF));
    pending_samples.push_back(mk(MODE_LOAD_VEL, 17'd1, 32'd0));
    pending_samples.push_back(mk(MODE_PREDICT, 17'd1, 32'hFFFF_FFFF));
    drain();

    // Zero variance and zero noise: correct with nonpositive denominator
    write_reg(REG_OBSERVATION_NOISE, 31'd0);
    write_reg(REG_INITIAL_VARIANCE, 31'd0);
    pending_samples.push_back(mk(MODE_CORRECT, 17'd0, 32'h0010_0000));
    pending_samples.push_back(mk(MODE_LOAD_POS, 17'd0, 32'h0002_0000));
    pending_samples.push_back(mk(MODE_CORRECT, 17'd0, 32'h8000_0000));
    drain();

    // Largest register values
    write_reg(REG_PROCESS_NOISE, MAX31);
    write_reg(REG_OBSERVATION_NOISE, MAX31);
    write_reg(REG_INITIAL_VARIANCE, MAX31);
    run_random(150);
    // Long receiver hold-off while the sender keeps offering items
    stall_hold = 600;
    drain();

    // Random settings, including the reset value of the process noise and other extremes
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_PROCESS_NOISE, ph == 0 ? 31'd0 : (ph == 1 ? CFG_RESET : 31'($urandom)));
      write_reg(REG_OBSERVATION_NOISE, ph == 2 ? 31'd1 : 31'($urandom_range(1, 1 << 20)));
      write_reg(REG_INITIAL_VARIANCE, ph == 3 ? 31'd0 : 31'($urandom_range(0, 1 << 22)));
      write_reg(2'd3, 31'($urandom));
      run_random(175);
      drain();
    end

    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/kpvf_pkg.sv
rtl/kpvf_if.sv
rtl/kpvf_mulq.sv
rtl/kpvf_divq.sv
rtl/kalman_pos_vel_filter.sv
rtl/kpvf_checker.sv
test/kpvf_tb_pkg.sv
test/tb_kalman_pos_vel_filter.sv
